FILE: rtl/pac_pkg.sv
// pac_pkg: shared constants of the pitot airspeed converter
// opcode codes, default widths and fixed arithmetic constants
// no dependencies

package pac_pkg;

    localparam int ADC_BITS_DEF        = 12;
    localparam int SPEED_FRAC_BITS_DEF = 10;

    localparam logic [1:0] OP_MEASURE   = 2'd0;
    localparam logic [1:0] OP_CALIBRATE = 2'd1;
    localparam logic [1:0] OP_SET_ZERO  = 2'd2;

    // qc / 101.325 kpa scaled: n * 2^(34-adc_bits) / 4053
    localparam logic [16:0] PRESS_DIV  = 17'd4053;
    localparam logic [16:0] DIV_7      = 17'd7;
    localparam logic [16:0] DIV_14     = 17'd14;
    localparam logic [16:0] DIV_28     = 17'd28;
    localparam logic [16:0] DIV_2000   = 17'd2000;
    localparam logic [31:0] SPEED_MUL  = 32'd1157836729;
    localparam int          SPEED_CAP_MPS = 59;

endpackage

FILE: rtl/pitot_airspeed_converter.sv
// pitot_airspeed_converter: calibration and airspeed from differential pressure
// one sequencer sharing a bit-serial divider, shift-add multiplier and square root
// depends on pac_pkg
//
// channel   dir  handshake           payload
// s_axis    in   s_tvalid/s_tready   tuser opcode, tdata sample/count/zero point
// m_axis    out  m_tvalid/m_tready   tuser result kind, tdata speed/zero/clipped
//
// measure: the pressure divide, the divide by 7, three rounds of multiply plus
// divide, the scale (multiply plus divide) and the square root; calibrate runs
// one divide, set zero and out-of-range measure go straight to the finish step
// the divider retires one quotient bit a cycle
// reset clears state, sum and offset; a new word is taken while a result waits
// on m_tready, the sequencer holds its last step until the output register frees

module pitot_airspeed_converter #(
    parameter int ADC_BITS        = pac_pkg::ADC_BITS_DEF,
    parameter int SPEED_FRAC_BITS = pac_pkg::SPEED_FRAC_BITS_DEF,
    localparam int S_DATA_W       = ((ADC_BITS + 32 + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // adc_sample, sample_count, zero_point_in
    input  logic [1:0]          s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // airspeed, zero_point, clipped
    output logic [1:0]          m_tuser    // result_kind
);

    localparam int ZERO_COUNTS = ((50 << ADC_BITS) + 33) / 66;
    localparam int Q_SHIFT     = 34 - ADC_BITS;
    localparam int S_SHIFT     = 32 - 2 * SPEED_FRAC_BITS;
    localparam logic [15:0] ZERO_CNT16 = 16'(ZERO_COUNTS);
    localparam logic signed [25:0] N_BASE  = 26'(25 << ADC_BITS);
    localparam logic signed [25:0] N_LIMIT = 26'(24 << ADC_BITS);
    localparam logic [31:0] SPEED_CAP = 32'(pac_pkg::SPEED_CAP_MPS << SPEED_FRAC_BITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_DIV,
        ST_Q_DIV,
        ST_T1_DIV,
        ST_T2_MUL,
        ST_T2_DIV,
        ST_T3_MUL,
        ST_T3_DIV,
        ST_T4_MUL,
        ST_T4_DIV,
        ST_SP_MUL,
        ST_SP_DIV,
        ST_ROOT,
        ST_FINISH
    } state_t;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic [15:0] r;
        begin
            r = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
            return r;
        end
    endfunction

    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] sum_reg, sum_next;
    logic [15:0] offset_reg, offset_next;
    logic [31:0] q_reg, q_next;
    logic [63:0] u_reg, u_next;
    logic [63:0] num_reg, num_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] speed_reg, speed_next;
    logic [15:0] zero_reg, zero_next;
    logic        clip_reg, clip_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [15:0] out_speed_reg, out_speed_next;
    logic [15:0] out_zero_reg, out_zero_next;
    logic        out_clip_reg, out_clip_next;

    logic [ADC_BITS-1:0] in_sample;
    logic [15:0]         in_count;
    logic [15:0]         in_zero;
    logic [15:0]         sample16;
    logic signed [17:0]  x_val;
    logic signed [25:0]  x_ext;
    logic signed [25:0]  n_val;
    logic [32:0]         sum_wide;
    logic [31:0]         sum_sat;
    logic [17:0]         div_r2;
    logic                div_ge;
    logic [17:0]         div_diff;
    logic [16:0]         div_rem;
    logic [63:0]         div_num;
    logic [63:0]         mul_acc;
    logic [31:0]         mul_hi;
    logic [33:0]         sq_r2;
    logic [33:0]         sq_trial;
    logic                sq_ge;
    logic [31:0]         sq_root;
    logic [15:0]         cal_zero;
    logic                cal_clip;

    assign in_sample = s_tdata[ADC_BITS-1:0];
    assign in_count  = s_tdata[ADC_BITS+15:ADC_BITS];
    assign in_zero   = s_tdata[ADC_BITS+31:ADC_BITS+16];

    assign sample16 = 16'(in_sample);
    assign x_val    = $signed({2'b00, sample16}) - $signed({{2{offset_reg[15]}}, offset_reg});
    assign x_ext    = 26'(x_val);
    assign n_val    = x_ext * 26'sd33 - N_BASE;

    assign sum_wide = {1'b0, sum_reg} + 33'(in_sample);
    assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

    // one restoring divide step
    assign div_r2   = {rem_reg[16:0], num_reg[63]};
    assign div_ge   = div_r2 >= {1'b0, den_reg};
    assign div_diff = div_r2 - {1'b0, den_reg};
    assign div_rem  = div_ge ? div_diff[16:0] : div_r2[16:0];
    assign div_num  = {num_reg[62:0], div_ge};

    // one shift-add multiply step
    assign mul_acc = mplier_reg[0] ? acc_reg + num_reg : acc_reg;
    assign mul_hi  = mul_acc[63:32];

    // one square root digit
    assign sq_r2    = {rem_reg[31:0], num_reg[63:62]};
    assign sq_trial = {acc_reg[31:0], 2'b01};
    assign sq_ge    = sq_r2 >= sq_trial;
    assign sq_root  = {acc_reg[30:0], sq_ge};

    assign cal_clip = div_num > 64'hFFFF;
    assign cal_zero = cal_clip ? 16'hFFFF : div_num[15:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'b0, out_clip_reg, out_zero_reg, out_speed_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + 6'd1;
        sum_next       = sum_reg;
        offset_next    = offset_reg;
        q_next         = q_reg;
        u_next         = u_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        acc_next       = acc_reg;
        mplier_next    = mplier_reg;
        kind_next      = kind_reg;
        speed_next     = speed_reg;
        zero_next      = zero_reg;
        clip_next      = clip_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_speed_next = out_speed_reg;
        out_zero_next  = out_zero_reg;
        out_clip_next  = out_clip_reg;

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 6'd0;
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    speed_next = 16'd0;
                    zero_next  = 16'd0;
                    clip_next  = 1'b0;
                    rem_next   = 34'd0;
                    state_next = ST_FINISH;
                    case (s_tuser)
                        pac_pkg::OP_MEASURE:
                        begin
                            if (n_val > N_LIMIT)
                            begin
                                speed_next = sat16(SPEED_CAP);
                                clip_next  = 1'b1;
                            end
                            else if (n_val > 26'sd0)
                            begin
                                num_next   = 64'(n_val[24:0]) << Q_SHIFT;
                                den_next   = pac_pkg::PRESS_DIV;
                                state_next = ST_Q_DIV;
                            end
                        end
                        pac_pkg::OP_CALIBRATE:
                        begin
                            sum_next  = sum_sat;
                            clip_next = sum_wide[32];
                            if (in_count == 16'd0)
                            begin
                                zero_next   = 16'hFFFF;
                                clip_next   = 1'b1;
                                offset_next = 16'hFFFF - ZERO_CNT16;
                            end
                            else
                            begin
                                num_next   = {31'd0, sum_sat, 1'b0} + 64'(in_count);
                                den_next   = {in_count, 1'b0};
                                state_next = ST_CAL_DIV;
                            end
                        end
                        pac_pkg::OP_SET_ZERO:
                        begin
                            zero_next   = in_zero;
                            offset_next = in_zero - ZERO_CNT16;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_CAL_DIV, ST_Q_DIV, ST_T1_DIV, ST_T2_DIV, ST_T3_DIV, ST_T4_DIV, ST_SP_DIV:
            begin
                num_next = div_num;
                rem_next = {17'd0, div_rem};
                if (cnt_reg == 6'd63)
                begin
                    cnt_next    = 6'd0;
                    rem_next    = 34'd0;
                    acc_next    = 64'd0;
                    mplier_next = q_reg;
                    case (state_reg)
                        ST_CAL_DIV:
                        begin
                            zero_next   = cal_zero;
                            clip_next   = clip_reg | cal_clip;
                            offset_next = cal_zero - ZERO_CNT16;
                            state_next  = ST_FINISH;
                        end
                        ST_Q_DIV:
                        begin
                            q_next     = div_num[31:0];
                            num_next   = {31'd0, div_num[31:0], 1'b0};
                            den_next   = pac_pkg::DIV_7;
                            state_next = ST_T1_DIV;
                        end
                        ST_T1_DIV:
                        begin
                            u_next     = div_num;
                            state_next = ST_T2_MUL;
                        end
                        ST_T2_DIV:
                        begin
                            u_next     = u_reg - div_num;
                            state_next = ST_T3_MUL;
                        end
                        ST_T3_DIV:
                        begin
                            u_next     = u_reg + div_num;
                            state_next = ST_T4_MUL;
                        end
                        ST_T4_DIV:
                        begin
                            u_next      = u_reg - div_num;
                            num_next    = u_reg - div_num;
                            mplier_next = pac_pkg::SPEED_MUL;
                            state_next  = ST_SP_MUL;
                        end
                        default:
                        begin
                            num_next   = div_num >> S_SHIFT;
                            state_next = ST_ROOT;
                        end
                    endcase
                end
            end

            ST_T2_MUL, ST_T3_MUL, ST_T4_MUL, ST_SP_MUL:
            begin
                acc_next    = mul_acc;
                num_next    = {num_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                if (cnt_reg == 6'd31)
                begin
                    cnt_next = 6'd0;
                    rem_next = 34'd0;
                    case (state_reg)
                        ST_T2_MUL:
                        begin
                            num_next   = 64'(mul_hi) * 64'd5;
                            den_next   = pac_pkg::DIV_14;
                            state_next = ST_T2_DIV;
                        end
                        ST_T3_MUL:
                        begin
                            num_next   = {30'd0, mul_hi, 2'b00};
                            den_next   = pac_pkg::DIV_7;
                            state_next = ST_T3_DIV;
                        end
                        ST_T4_MUL:
                        begin
                            num_next   = 64'(mul_hi) * 64'd19;
                            den_next   = pac_pkg::DIV_28;
                            state_next = ST_T4_DIV;
                        end
                        default:
                        begin
                            num_next   = mul_acc;
                            den_next   = pac_pkg::DIV_2000;
                            state_next = ST_SP_DIV;
                        end
                    endcase
                end
            end

            ST_ROOT:
            begin
                rem_next = sq_ge ? sq_r2 - sq_trial : sq_r2;
                acc_next = {32'd0, sq_root};
                num_next = {num_reg[61:0], 2'b00};
                if (cnt_reg == 6'd31)
                begin
                    cnt_next   = 6'd0;
                    state_next = ST_FINISH;
                    if (sq_root > SPEED_CAP)
                    begin
                        speed_next = sat16(SPEED_CAP);
                        clip_next  = 1'b1;
                    end
                    else
                    begin
                        speed_next = sat16(sq_root);
                    end
                end
            end

            ST_FINISH:
            begin
                cnt_next = 6'd0;
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    out_kind_next  = kind_reg;
                    out_speed_next = speed_reg;
                    out_zero_next  = zero_reg;
                    out_clip_next  = clip_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 6'd0;
            sum_reg       <= 32'd0;
            offset_reg    <= 16'd0;
            m_tvalid_reg  <= 1'b0;
            q_reg         <= 32'd0;
            u_reg         <= 64'd0;
            num_reg       <= 64'd0;
            rem_reg       <= 34'd0;
            den_reg       <= 17'd0;
            acc_reg       <= 64'd0;
            mplier_reg    <= 32'd0;
            kind_reg      <= 2'd0;
            speed_reg     <= 16'd0;
            zero_reg      <= 16'd0;
            clip_reg      <= 1'b0;
            out_kind_reg  <= 2'd0;
            out_speed_reg <= 16'd0;
            out_zero_reg  <= 16'd0;
            out_clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            offset_reg    <= offset_next;
            m_tvalid_reg  <= m_tvalid_next;
            q_reg         <= q_next;
            u_reg         <= u_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            den_reg       <= den_next;
            acc_reg       <= acc_next;
            mplier_reg    <= mplier_next;
            kind_reg      <= kind_next;
            speed_reg     <= speed_next;
            zero_reg      <= zero_next;
            clip_reg      <= clip_next;
            out_kind_reg  <= out_kind_next;
            out_speed_reg <= out_speed_next;
            out_zero_reg  <= out_zero_next;
            out_clip_reg  <= out_clip_next;
        end
    end

endmodule
